// ----- src/hft_pkg.sv -----
// Shared types and constants for the header field tokenizer.
// No dependencies; imported by every module of the block.
package hft_pkg;

   localparam int HFT_MAX_LENGTH  = 65536;
   localparam int HFT_MAX_HEADERS = 64;

   localparam logic [7:0] BYTE_CR    = 8'd13;
   localparam logic [7:0] BYTE_LF    = 8'd10;
   localparam logic [7:0] BYTE_COLON = 8'd58;
   localparam logic [7:0] BYTE_SPACE = 8'd32;
   localparam logic [7:0] BYTE_NUL   = 8'd0;

   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_KEY,
      PH_WS,
      PH_VALUE
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] key_start;
      logic [15:0] key_length;
      logic [15:0] value_start;
      logic [15:0] value_length;
      logic [5:0]  header_index;
      logic [16:0] consumed;
      logic        overflow;
      logic        last_result;
   } hft_result_type;

   // Up to two results per byte: a record, then possibly the closing done.
   typedef struct packed {
      logic           r0_valid;
      hft_result_type r0;
      logic           r1_valid;
      hft_result_type r1;
   } hft_pair_type;

endpackage

// ----- src/hft_parse_core.sv -----
// Line parser state and per-byte result logic, plus the start offset register.
// Depends on hft_pkg.
module hft_parse_core #(
   parameter int MAX_LENGTH  = hft_pkg::HFT_MAX_LENGTH,
   parameter int MAX_HEADERS = hft_pkg::HFT_MAX_HEADERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  logic                in_end,
   output hft_pkg::hft_pair_type pair
);
   import hft_pkg::*;

   localparam int PW = $clog2(MAX_LENGTH);
   localparam int HW = $clog2(MAX_HEADERS + 1);
   localparam int XW = (PW + 1 > 17) ? PW + 1 : 17;
   localparam logic [PW-1:0] LAST_POS = PW'(MAX_LENGTH - 1);
   localparam logic [HW-1:0] CAP      = HW'(MAX_HEADERS);

   logic [15:0]   start_offset_ff;
   phase_type     phase_ff, phase_in;
   logic [PW-1:0] position_ff, position_in;
   logic [PW-1:0] line_start_ff, line_start_in;
   logic [PW-1:0] colon_ff, colon_in;
   logic [PW-1:0] value_begin_ff, value_begin_in;
   logic          cr_pending_ff, cr_pending_in;
   logic [HW-1:0] header_count_ff, header_count_in;
   logic          seen_first_ff, seen_first_in;
   logic          overflowed_ff, overflowed_in;

   always_comb begin
      logic [XW-1:0] pos_x;
      logic [XW-1:0] ls_x;
      logic [XW-1:0] col_x;
      logic [XW-1:0] vb_x;
      logic [XW-1:0] kl_x;
      logic [XW-1:0] vl_x;
      logic [XW-1:0] cons_x;
      logic [XW-1:0] cnt_x;
      logic          end_b;
      logic          do_fin;
      logic [1:0]    fin_kind;
      logic          go_key;
      logic          go_value;
      logic          cr_cur;
      logic          rec_v;
      logic          rec_ovf;
      hft_result_type rec;
      hft_result_type fin;

      phase_in        = phase_ff;
      position_in     = position_ff + PW'(1);
      line_start_in   = line_start_ff;
      colon_in        = colon_ff;
      value_begin_in  = value_begin_ff;
      cr_pending_in   = cr_pending_ff;
      header_count_in = header_count_ff;
      seen_first_in   = seen_first_ff;
      overflowed_in   = overflowed_ff;

      pos_x    = XW'(position_ff);
      ls_x     = '0;
      col_x    = XW'(colon_ff);
      vb_x     = '0;
      kl_x     = '0;
      vl_x     = '0;
      cons_x   = '0;
      cnt_x    = XW'(header_count_ff);
      end_b    = in_end || (position_ff == LAST_POS);
      do_fin   = 1'b0;
      fin_kind = KIND_DONE;
      go_key   = 1'b0;
      go_value = 1'b0;
      cr_cur   = cr_pending_ff;
      rec_v    = 1'b0;
      rec_ovf  = 1'b0;
      rec      = '0;
      fin      = '0;

      case (phase_ff)
         PH_SKIP: begin
            if (pos_x < XW'(start_offset_ff)) begin
               if (end_b) begin
                  do_fin   = 1'b1;
                  fin_kind = KIND_ERROR;
               end
            end else begin
               seen_first_in = 1'b1;
               if (in_byte == BYTE_NUL) begin
                  do_fin   = 1'b1;
                  fin_kind = KIND_ERROR;
               end else if (in_byte inside {BYTE_CR, BYTE_LF}) begin
                  if (end_b) begin
                     do_fin   = 1'b1;
                     fin_kind = KIND_ERROR;
                  end
               end else if (end_b && !seen_first_ff) begin
                  // first parsed byte is also the last one
                  do_fin   = 1'b1;
                  fin_kind = KIND_ERROR;
               end else begin
                  line_start_in = position_ff;
                  go_key        = 1'b1;
               end
            end
         end
         PH_KEY: begin
            go_key = 1'b1;
         end
         PH_WS: begin
            if (in_byte == BYTE_NUL) begin
               do_fin = 1'b1;
               cons_x = XW'(line_start_ff);
            end else if (in_byte <= BYTE_SPACE) begin
               if (end_b) begin
                  do_fin = 1'b1;
                  cons_x = XW'(line_start_ff);
               end
            end else begin
               value_begin_in = position_ff;
               cr_cur         = 1'b0;
               go_value       = 1'b1;
            end
         end
         PH_VALUE: begin
            go_value = 1'b1;
         end
         default: begin
            phase_in        = PH_SKIP;
            position_in     = '0;
            line_start_in   = '0;
            colon_in        = '0;
            value_begin_in  = '0;
            cr_pending_in   = 1'b0;
            header_count_in = '0;
            seen_first_in   = 1'b0;
            overflowed_in   = 1'b0;
         end
      endcase

      if (go_key) begin
         phase_in = PH_KEY;
         if (in_byte == BYTE_NUL || end_b) begin
            do_fin = 1'b1;
            cons_x = XW'(line_start_in);
         end else if (in_byte == BYTE_COLON) begin
            colon_in = position_ff;
            phase_in = PH_WS;
         end
      end

      if (go_value) begin
         phase_in = PH_VALUE;
         vb_x     = XW'(value_begin_in);
         if (cr_cur && in_byte == BYTE_LF) begin
            ls_x    = XW'(line_start_ff);
            kl_x    = col_x - ls_x;
            vl_x    = pos_x - XW'(1) - vb_x;
            rec_ovf = (header_count_ff == CAP);
            rec_v   = 1'b1;
            rec.kind         = KIND_RECORD;
            rec.key_start    = ls_x[15:0];
            rec.key_length   = kl_x[15:0];
            rec.value_start  = vb_x[15:0];
            rec.value_length = vl_x[15:0];
            rec.header_index = cnt_x[5:0];
            rec.overflow     = rec_ovf;
            if (rec_ovf) begin
               overflowed_in = 1'b1;
            end else begin
               header_count_in = header_count_ff + HW'(1);
            end
            line_start_in = position_ff + PW'(1);
            cr_pending_in = 1'b0;
            phase_in      = PH_KEY;
            if (end_b) begin
               // line closes on the final byte: consumed runs past the LF
               do_fin = 1'b1;
               cons_x = pos_x + XW'(1);
            end
         end else if (in_byte == BYTE_NUL || end_b) begin
            do_fin = 1'b1;
            cons_x = XW'(line_start_ff);
         end else begin
            cr_pending_in = (in_byte == BYTE_CR);
         end
      end

      if (do_fin) begin
         fin.kind        = fin_kind;
         fin.consumed    = (fin_kind == KIND_DONE) ? cons_x[16:0] : 17'd0;
         fin.overflow    = overflowed_in;
         fin.last_result = 1'b1;
         phase_in        = PH_SKIP;
         position_in     = '0;
         line_start_in   = '0;
         colon_in        = '0;
         value_begin_in  = '0;
         cr_pending_in   = 1'b0;
         header_count_in = '0;
         seen_first_in   = 1'b0;
         overflowed_in   = 1'b0;
      end

      pair = '0;
      if (rec_v) begin
         pair.r0_valid = 1'b1;
         pair.r0       = rec;
         pair.r1_valid = do_fin;
         pair.r1       = fin;
      end else begin
         pair.r0_valid = do_fin;
         pair.r0       = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= '0;
         phase_ff        <= PH_SKIP;
         position_ff     <= '0;
         line_start_ff   <= '0;
         colon_ff        <= '0;
         value_begin_ff  <= '0;
         cr_pending_ff   <= 1'b0;
         header_count_ff <= '0;
         seen_first_ff   <= 1'b0;
         overflowed_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            start_offset_ff <= csr_wdata;
         end
         if (step) begin
            phase_ff        <= phase_in;
            position_ff     <= position_in;
            line_start_ff   <= line_start_in;
            colon_ff        <= colon_in;
            value_begin_ff  <= value_begin_in;
            cr_pending_ff   <= cr_pending_in;
            header_count_ff <= header_count_in;
            seen_first_ff   <= seen_first_in;
            overflowed_ff   <= overflowed_in;
         end
      end
   end

   a_second_is_done: assert property (@(posedge clock) disable iff (reset)
      pair.r1_valid |-> (pair.r0_valid && pair.r0.kind == KIND_RECORD
                         && pair.r1.last_result && pair.r1.kind == KIND_DONE))
      else $error("second result must be a done after a record");

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (step && pair.r0_valid && pair.r0.last_result) |=>
         (position_ff == '0 && phase_ff == PH_SKIP && header_count_ff == '0))
      else $error("message state not cleared after final result");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= CAP)
      else $error("header count beyond capacity");

endmodule

// ----- src/hft_out_buffer.sv -----
// Result register with one spare slot for the second result of a byte.
// Depends on hft_pkg.
module hft_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  hft_pkg::hft_pair_type  pair,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hft_pkg::hft_result_type out_result
);
   import hft_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           extra_valid_ff, extra_valid_in;
   hft_result_type out_ff, out_in;
   hft_result_type extra_ff, extra_in;
   logic           pop;

   assign pop   = out_valid_ff && out_ready;
   assign space = !extra_valid_ff && (!out_valid_ff || pop);

   always_comb begin
      out_valid_in   = out_valid_ff;
      extra_valid_in = extra_valid_ff;
      out_in         = out_ff;
      extra_in       = extra_ff;
      if (step) begin
         out_valid_in   = pair.r0_valid;
         out_in         = pair.r0;
         extra_valid_in = pair.r1_valid;
         extra_in       = pair.r1;
      end else if (pop) begin
         out_valid_in   = extra_valid_ff;
         out_in         = extra_ff;
         extra_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         extra_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         extra_valid_ff <= extra_valid_in;
      end
      out_ff   <= out_in;
      extra_ff <= extra_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

   a_extra_behind_out: assert property (@(posedge clock) disable iff (reset)
      extra_valid_ff |-> out_valid_ff)
      else $error("spare slot filled while result register empty");

   a_no_step_when_full: assert property (@(posedge clock) disable iff (reset)
      step |-> space)
      else $error("byte processed without room for its results");

endmodule

// ----- src/header_field_tokenizer_unit.sv -----
// Top level of the header field tokenizer: input register, parser, result buffer.
// Depends on hft_pkg, hft_parse_core and hft_out_buffer.
//
// Usage:
//   req_*  : one header byte per transfer, tlast marks the final byte of a buffer.
//   rsp_*  : results; tuser is the kind (record, done, error), tlast marks the
//            final result of a message. After it the next byte is offset 0 again.
//   csr_*  : start offset register, written while the block is idle.
// Path: a byte taken on req is held in the input register while it is parsed;
//   its results are registered in the result register and presented on rsp.
// Throughput: one byte per cycle while rsp_tready is high and the spare slot is
//   empty. A byte that closes a line on the last byte gives two results; the
//   second sits in a spare slot and the parser waits for it to drain.
// Stall: when rsp_tready is low the result register holds, the parser stops and
//   req_tready drops once the input register holds a byte.
// Reset: synchronous; clears the start offset to 0 and all parse state.
module header_field_tokenizer_unit #(
   parameter int MAX_LENGTH  = hft_pkg::HFT_MAX_LENGTH,
   parameter int MAX_HEADERS = hft_pkg::HFT_MAX_HEADERS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // key_start, key_length, value_start, value_length,
                                    // header_index, consumed, overflow (lowest first)
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last_result
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import hft_pkg::*;

   logic           s1_valid_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_end_ff;
   logic           s1_fire;
   logic           space;
   hft_pair_type   pair;
   hft_result_type res;

   assign s1_fire    = s1_valid_ff && space;
   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_end_ff  <= req_tlast;
      end
   end

   hft_parse_core #(
      .MAX_LENGTH  (MAX_LENGTH),
      .MAX_HEADERS (MAX_HEADERS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (s1_fire),
      .in_byte   (s1_byte_ff),
      .in_end    (s1_end_ff),
      .pair      (pair)
   );

   hft_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_fire),
      .pair       (pair),
      .space      (space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (res)
   );

   assign rsp_tdata = {res.overflow, res.consumed, res.header_index, res.value_length,
                       res.value_start, res.key_length, res.key_start};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last_result;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stalled with an empty input register");

   a_last_not_record: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_RECORD)))
      else $error("final-result flag does not match result kind");

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for header_field_tokenizer_unit: byte stream in, header records out.
// Depends on hft_pkg and the RTL under src; the expected records come from a local tokenizer.
`timescale 1ns / 100ps

module tb_top;
   import hft_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 8;     // pipeline is two deep; leave margin
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;  // longest quiet stretch is the hold plus a drain
   localparam int MAX_PRINTED    = 40;
   localparam int CAP_LINES      = HFT_MAX_HEADERS + 2;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type  op;
      logic [15:0] value;     // byte for ROW_BYTE, offset for ROW_CSR
      logic        last;
      bit          typed;     // expected result given in the row
      logic [1:0]  kind;
      logic [16:0] consumed;
   } dir_row_type;

   typedef struct {
      logic [7:0]     data;
      logic           last;
      bit             typed;
      hft_result_type want;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   header_field_tokenizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- tokenizer
   phase_type   tok_phase;
   logic [16:0] tok_pos;
   logic [15:0] tok_line_start;
   logic [15:0] tok_colon;
   logic [15:0] tok_value_begin;
   logic        tok_cr_pending;
   logic [6:0]  tok_header_count;
   logic        tok_seen_first;
   logic        tok_overflowed;
   logic [15:0] tok_offset;

   hft_result_type pending_results[$];

   function automatic void clear_tokenizer();
      tok_phase        = PH_SKIP;
      tok_pos          = '0;
      tok_line_start   = '0;
      tok_colon        = '0;
      tok_value_begin  = '0;
      tok_cr_pending   = 1'b0;
      tok_header_count = '0;
      tok_seen_first   = 1'b0;
      tok_overflowed   = 1'b0;
   endfunction

   function automatic void close_message(logic [1:0] kind, logic [16:0] cons);
      hft_result_type r;
      r             = '0;
      r.kind        = kind;
      r.consumed    = (kind == KIND_DONE) ? cons : 17'd0;
      r.overflow    = tok_overflowed;
      r.last_result = 1'b1;
      pending_results.push_back(r);
      clear_tokenizer();
   endfunction

   function automatic void tokenize_byte(logic [7:0] b, logic last);
      logic [16:0]    pos;
      logic           at_end;
      logic           first;
      logic           ovf;
      hft_result_type rec;
      pos     = tok_pos;
      at_end  = last || (pos >= 17'(HFT_MAX_LENGTH - 1));
      tok_pos = pos + 17'd1;

      if (tok_phase == PH_SKIP) begin
         if (pos < {1'b0, tok_offset}) begin
            if (at_end) close_message(KIND_ERROR, '0);
            return;
         end
         first          = !tok_seen_first;
         tok_seen_first = 1'b1;
         if (b == BYTE_NUL || ((b == BYTE_CR || b == BYTE_LF) && at_end) || (at_end && first))
         begin
            close_message(KIND_ERROR, '0);
            return;
         end
         if (b == BYTE_CR || b == BYTE_LF) return;
         tok_line_start = pos[15:0];
         tok_phase      = PH_KEY;
      end

      if (tok_phase == PH_KEY) begin
         if (b == BYTE_NUL || at_end) begin
            close_message(KIND_DONE, {1'b0, tok_line_start});
         end else if (b == BYTE_COLON) begin
            tok_colon = pos[15:0];
            tok_phase = PH_WS;
         end
         return;
      end

      if (tok_phase == PH_WS) begin
         // anything from 1 to space after the colon is padding, CR/LF included
         if (b == BYTE_NUL || (b <= BYTE_SPACE && at_end)) begin
            close_message(KIND_DONE, {1'b0, tok_line_start});
            return;
         end
         if (b <= BYTE_SPACE) return;
         tok_value_begin = pos[15:0];
         tok_cr_pending  = 1'b0;
         tok_phase       = PH_VALUE;
      end

      if (tok_phase == PH_VALUE) begin
         if (tok_cr_pending && b == BYTE_LF) begin
            ovf = (tok_header_count >= 7'(HFT_MAX_HEADERS));
            if (ovf) tok_overflowed = 1'b1;
            rec              = '0;
            rec.kind         = KIND_RECORD;
            rec.key_start    = tok_line_start;
            rec.key_length   = tok_colon - tok_line_start;
            rec.value_start  = tok_value_begin;
            rec.value_length = pos[15:0] - 16'd1 - tok_value_begin;
            rec.header_index = tok_header_count[5:0];
            rec.overflow     = ovf;
            pending_results.push_back(rec);
            if (!ovf) tok_header_count = tok_header_count + 7'd1;
            tok_line_start = pos[15:0] + 16'd1;
            tok_cr_pending = 1'b0;
            tok_phase      = PH_KEY;
            if (at_end) close_message(KIND_DONE, pos + 17'd1);
            return;
         end
         if (b == BYTE_NUL || at_end) begin
            close_message(KIND_DONE, {1'b0, tok_line_start});
            return;
         end
         tok_cr_pending = (b == BYTE_CR);
      end
   endfunction

   // ---------------------------------------------------------------- sender
   byte_item_type send_queue[$];
   byte_item_type cur_item;
   int            pushed_count   = 0;
   int            accepted_count = 0;
   int            burst_left     = 0;
   int            gap_left       = 0;

   always @(posedge clock) begin
      bit took;
      int depth;
      took = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (took) begin
            depth = pending_results.size();
            tokenize_byte(cur_item.data, cur_item.last);
            if (cur_item.typed) begin
               while (pending_results.size() > depth) void'(pending_results.pop_back());
               pending_results.push_back(cur_item.want);
            end
            accepted_count++;
         end
         if (!req_tvalid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (send_queue.size() > 0) begin
               cur_item = send_queue.pop_front();
               req_tdata  <= cur_item.data;
               req_tlast  <= cur_item.last;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   int mismatches    = 0;
   int results_seen  = 0;
   int records_seen  = 0;
   int dones_seen    = 0;
   int errors_seen   = 0;
   int overflow_seen = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int pattern_step  = 0;
   int stall_pct     = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch on result transfer %0d: %s got %0h expected %0h",
                  results_seen, what, got_v, want_v);
   endtask

   always @(posedge clock) begin
      hft_result_type got;
      hft_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind         = rsp_tuser;
            got.key_start    = rsp_tdata[15:0];
            got.key_length   = rsp_tdata[31:16];
            got.value_start  = rsp_tdata[47:32];
            got.value_length = rsp_tdata[63:48];
            got.header_index = rsp_tdata[69:64];
            got.consumed     = rsp_tdata[86:70];
            got.overflow     = rsp_tdata[87];
            got.last_result  = rsp_tlast;
            results_seen++;
            case (got.kind)
               KIND_RECORD: records_seen++;
               KIND_DONE:   dones_seen++;
               default:     errors_seen++;
            endcase
            if (got.kind == KIND_RECORD && got.overflow) overflow_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected, kind", 32'(got.kind), 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (got.kind != want.kind)
                  report_mismatch("kind", 32'(got.kind), 32'(want.kind));
               if (got.key_start != want.key_start)
                  report_mismatch("key_start", 32'(got.key_start), 32'(want.key_start));
               if (got.key_length != want.key_length)
                  report_mismatch("key_length", 32'(got.key_length), 32'(want.key_length));
               if (got.value_start != want.value_start)
                  report_mismatch("value_start", 32'(got.value_start),
                                  32'(want.value_start));
               if (got.value_length != want.value_length)
                  report_mismatch("value_length", 32'(got.value_length),
                                  32'(want.value_length));
               if (got.header_index != want.header_index)
                  report_mismatch("header_index", 32'(got.header_index),
                                  32'(want.header_index));
               if (got.consumed != want.consumed)
                  report_mismatch("consumed", 32'(got.consumed), 32'(want.consumed));
               if (got.overflow != want.overflow)
                  report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
               if (got.last_result != want.last_result)
                  report_mismatch("last_result", 32'(got.last_result),
                                  32'(want.last_result));
            end
         end

         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_step % 64 == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 60;
                  default: stall_pct = 90;
               endcase
            end
            pattern_step++;
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   dir_row_type directed_rows [0:27] = '{
      '{ROW_BYTE, 16'h000D, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h000A, 1'b1, 1'b1, KIND_ERROR,  17'd0},  // nothing but CR/LF
      '{ROW_BYTE, 16'h0041, 1'b1, 1'b1, KIND_ERROR,  17'd0},  // first byte is also last
      '{ROW_BYTE, 16'h0000, 1'b0, 1'b1, KIND_ERROR,  17'd0},  // NUL in leading skip
      '{ROW_BYTE, 16'h004B, 1'b0, 1'b0, KIND_RECORD, 17'd0},  // "K: <ff>\r\n"
      '{ROW_BYTE, 16'h003A, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h0020, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h00FF, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h000D, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h000A, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h0001, 1'b0, 1'b0, KIND_RECORD, 17'd0},  // incomplete line
      '{ROW_BYTE, 16'h0080, 1'b1, 1'b1, KIND_DONE,   17'd6},
      '{ROW_BYTE, 16'h0078, 1'b0, 1'b0, KIND_RECORD, 17'd0},  // "x:y\r\n", LF is last
      '{ROW_BYTE, 16'h003A, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h0079, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h000D, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h000A, 1'b1, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_CSR,  16'd3,    1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h0000, 1'b0, 1'b0, KIND_RECORD, 17'd0},  // NUL below offset ignored
      '{ROW_BYTE, 16'h007A, 1'b1, 1'b1, KIND_ERROR,  17'd0},  // ends before offset
      '{ROW_BYTE, 16'h0061, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h0062, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h0063, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h000A, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h006B, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h003A, 1'b0, 1'b0, KIND_RECORD, 17'd0},
      '{ROW_BYTE, 16'h0000, 1'b0, 1'b1, KIND_DONE,   17'd4},  // NUL inside padding
      '{ROW_CSR,  16'd0,    1'b0, 1'b0, KIND_RECORD, 17'd0}
   };

   int phase_offset = 0;

   function automatic void push_byte(logic [7:0] data, logic last);
      byte_item_type it;
      it.data  = data;
      it.last  = last;
      it.typed = 1'b0;
      it.want  = '0;
      send_queue.push_back(it);
      pushed_count++;
   endfunction

   function automatic logic [7:0] key_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(1, 255)); while (v == BYTE_COLON);
      return v;
   endfunction

   // wait for every byte to be taken and every result to arrive, then let the
   // pipeline empty out bytes that produce no result
   task automatic drain_block();
      while (accepted_count != pushed_count || pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tok_offset = value;
   endtask

   // one message: mostly well-formed lines with random content, some cut
   // short, NUL-terminated or plain noise
   function automatic int gen_message();
      logic [7:0] msg[$];
      int         ending;
      int         last_at;
      msg = {};
      repeat (phase_offset) msg.push_back(8'($urandom));
      repeat ($urandom_range(0, 2)) msg.push_back($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
      repeat ($urandom_range(1, 4)) begin
         repeat ($urandom_range(0, 6)) msg.push_back(key_byte());
         msg.push_back(BYTE_COLON);
         repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(1, 32)));
         msg.push_back(8'($urandom_range(33, 255)));
         repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom_range(1, 255)));
         msg.push_back(BYTE_CR);
         msg.push_back(BYTE_LF);
      end
      ending = $urandom_range(0, 19);
      if (ending < 6) begin
         last_at = msg.size() - 1;
      end else if (ending < 10) begin
         repeat ($urandom_range(1, 4)) msg.push_back(key_byte());
         last_at = msg.size() - 1;
      end else if (ending < 13) begin
         msg.push_back(BYTE_NUL);
         last_at = -1;
      end else if (ending < 17) begin
         last_at = $urandom_range(0, msg.size() - 1);
         while (msg.size() > last_at + 1) void'(msg.pop_back());
      end else begin
         msg = {};
         repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom));
         last_at = $urandom_range(0, 1) ? msg.size() - 1 : -1;
      end
      foreach (msg[i]) push_byte(msg[i], i == last_at);
      return msg.size();
   endfunction

   task automatic run_random(input int target);
      int sent;
      sent = 0;
      while (sent < target) sent += gen_message();
      push_byte(BYTE_NUL, 1'b1);   // closes whatever message is open
   endtask

   // a message of short lines that runs past header capacity; the last LF
   // carries tlast
   task automatic gen_capacity_message();
      for (int i = 0; i < CAP_LINES; i++) begin
         push_byte(8'($urandom_range(97, 122)), 1'b0);
         push_byte(BYTE_COLON, 1'b0);
         push_byte(8'($urandom_range(33, 126)), 1'b0);
         push_byte(BYTE_CR, 1'b0);
         push_byte(BYTE_LF, i == CAP_LINES - 1);
      end
   endtask

   task automatic run_short_errors(input int count);
      int n;
      repeat (count) begin
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
      end
   endtask

   initial begin
      byte_item_type it;
      tok_offset = '0;
      clear_tokenizer();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_CSR) begin
            drain_block();
            write_offset(directed_rows[i].value);
         end else begin
            it.data               = directed_rows[i].value[7:0];
            it.last               = directed_rows[i].last;
            it.typed              = directed_rows[i].typed;
            it.want               = '0;
            it.want.kind          = directed_rows[i].kind;
            it.want.consumed      = directed_rows[i].consumed;
            it.want.last_result   = 1'b1;
            send_queue.push_back(it);
            pushed_count++;
         end
      end

      run_random(80);
      drain_block();

      // offsets out of reach: every short message ends before the offset
      write_offset(16'hFFFF);
      run_short_errors(6);
      drain_block();
      write_offset(16'h8000 | 16'($urandom_range(0, 16'h7FFE)));
      run_short_errors(4);
      drain_block();

      // receiver holds off while the queue is full so the input backs up
      phase_offset = $urandom_range(1, 12);
      write_offset(16'(phase_offset));
      run_random(40);
      hold_asked++;
      run_random(40);
      drain_block();

      phase_offset = 0;
      write_offset(16'd0);
      gen_capacity_message();
      drain_block();

      phase_offset = $urandom_range(0, 3);
      write_offset(16'(phase_offset));
      run_random(80);
      drain_block();

      $display("covered %0d bytes over offsets 0 to 65535 and one message past header capacity",
               accepted_count);
      $display("checked %0d records (%0d past capacity), %0d done and %0d error results",
               records_seen, overflow_seen, dones_seen, errors_seen);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- header_field_tokenizer_unit.f -----
src/hft_pkg.sv
src/hft_parse_core.sv
src/hft_out_buffer.sv
src/header_field_tokenizer_unit.sv
test/tb_top.sv
